[design/fcm_pkg.sv]
// shared types, constants and lookup functions of the false-color mapper
package fcm_pkg;

    localparam int MAX_COLORS_DEF = 6;
    localparam int PALETTE_SIZE   = 6;
    localparam int CHAN_W         = 8;
    localparam int COLOR_W        = 3 * CHAN_W;
    localparam int CNT_W          = 3;
    localparam int RECIP_W        = 19;
    localparam int RECIP_SHIFT    = 24;
    localparam int NUM_STAGES     = 6;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    // register index, byte address is four times the index
    typedef enum logic [2:0] {
        REG_SOFT_MODE   = 3'd0,
        REG_COLOR_COUNT = 3'd1,
        REG_COLOR_0     = 3'd2,
        REG_COLOR_1     = 3'd3,
        REG_COLOR_2     = 3'd4,
        REG_COLOR_3     = 3'd5,
        REG_COLOR_4     = 3'd6,
        REG_COLOR_5     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                                  soft_mode;
        logic [CNT_W-1:0]                      color_count;
        logic [PALETTE_SIZE-1:0][COLOR_W-1:0]  colors;
    } cfg_t;

    // segment of the gray axis between two knots
    typedef struct packed {
        logic [CHAN_W-1:0]  l;
        logic [CHAN_W-1:0]  span;
        logic [RECIP_W-1:0] recip;
    } seg_t;

    // what the index stage hands to the channel lanes
    typedef struct packed {
        logic [CHAN_W-1:0]  off;
        logic [CHAN_W-1:0]  span;
        logic [RECIP_W-1:0] recip;
        logic [COLOR_W-1:0] c_lo;
        logic [COLOR_W-1:0] c_hi;
    } knot_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

    // floor(x / 255) for x below 2040
    function automatic logic [CNT_W-1:0] div255(input logic [10:0] x);
        logic [11:0] sum;
        sum = {1'b0, x} + {9'b0, x[10:8]} + 12'd1;
        return sum[10:8];
    endfunction

    // knot position, span and floor(2^24 / span) for n entries and lower knot
    function automatic seg_t seg_lookup(input logic [CNT_W-1:0] n,
                                        input logic [CNT_W-1:0] low);
        seg_t s;
        s = '{l: 8'd0, span: 8'd1, recip: 19'd0};
        case ({n, low})
            {3'd2, 3'd0}: s = '{l: 8'd0,   span: 8'd255, recip: 19'd65793};
            {3'd3, 3'd0}: s = '{l: 8'd0,   span: 8'd127, recip: 19'd132104};
            {3'd3, 3'd1}: s = '{l: 8'd127, span: 8'd128, recip: 19'd131072};
            {3'd4, 3'd0}: s = '{l: 8'd0,   span: 8'd85,  recip: 19'd197379};
            {3'd4, 3'd1}: s = '{l: 8'd85,  span: 8'd85,  recip: 19'd197379};
            {3'd4, 3'd2}: s = '{l: 8'd170, span: 8'd85,  recip: 19'd197379};
            {3'd5, 3'd0}: s = '{l: 8'd0,   span: 8'd63,  recip: 19'd266305};
            {3'd5, 3'd1}: s = '{l: 8'd63,  span: 8'd64,  recip: 19'd262144};
            {3'd5, 3'd2}: s = '{l: 8'd127, span: 8'd64,  recip: 19'd262144};
            {3'd5, 3'd3}: s = '{l: 8'd191, span: 8'd64,  recip: 19'd262144};
            {3'd6, 3'd0}: s = '{l: 8'd0,   span: 8'd51,  recip: 19'd328965};
            {3'd6, 3'd1}: s = '{l: 8'd51,  span: 8'd51,  recip: 19'd328965};
            {3'd6, 3'd2}: s = '{l: 8'd102, span: 8'd51,  recip: 19'd328965};
            {3'd6, 3'd3}: s = '{l: 8'd153, span: 8'd51,  recip: 19'd328965};
            {3'd6, 3'd4}: s = '{l: 8'd204, span: 8'd51,  recip: 19'd328965};
            default:      s = '{l: 8'd0,   span: 8'd1,   recip: 19'd0};
        endcase
        return s;
    endfunction

endpackage

[design/fcm_regs.sv]
// configuration registers behind the apb port
module fcm_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcm_pkg::ADDR_W-1:0]  paddr,
    input  logic [fcm_pkg::DATA_W-1:0]  pwdata,
    output logic [fcm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output fcm_pkg::cfg_t               cfg
);
    import fcm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.soft_mode   <= 1'b0;
            cfg_reg.color_count <= CNT_W'(4);
            cfg_reg.colors[0]   <= 24'h000000;
            cfg_reg.colors[1]   <= 24'hFF0000;
            cfg_reg.colors[2]   <= 24'hFFFFFF;
            cfg_reg.colors[3]   <= 24'hFFFFFF;
            cfg_reg.colors[4]   <= 24'h000000;
            cfg_reg.colors[5]   <= 24'h000000;
        end else if (wr_en) begin
            unique case (idx)
                REG_SOFT_MODE:   cfg_reg.soft_mode   <= pwdata[0];
                REG_COLOR_COUNT: cfg_reg.color_count <= pwdata[CNT_W-1:0];
                REG_COLOR_0:     cfg_reg.colors[0]   <= pwdata[COLOR_W-1:0];
                REG_COLOR_1:     cfg_reg.colors[1]   <= pwdata[COLOR_W-1:0];
                REG_COLOR_2:     cfg_reg.colors[2]   <= pwdata[COLOR_W-1:0];
                REG_COLOR_3:     cfg_reg.colors[3]   <= pwdata[COLOR_W-1:0];
                REG_COLOR_4:     cfg_reg.colors[4]   <= pwdata[COLOR_W-1:0];
                REG_COLOR_5:     cfg_reg.colors[5]   <= pwdata[COLOR_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_SOFT_MODE:   prdata = DATA_W'(cfg_reg.soft_mode);
            REG_COLOR_COUNT: prdata = DATA_W'(cfg_reg.color_count);
            REG_COLOR_0:     prdata = DATA_W'(cfg_reg.colors[0]);
            REG_COLOR_1:     prdata = DATA_W'(cfg_reg.colors[1]);
            REG_COLOR_2:     prdata = DATA_W'(cfg_reg.colors[2]);
            REG_COLOR_3:     prdata = DATA_W'(cfg_reg.colors[3]);
            REG_COLOR_4:     prdata = DATA_W'(cfg_reg.colors[4]);
            REG_COLOR_5:     prdata = DATA_W'(cfg_reg.colors[5]);
            default:         prdata = '0;
        endcase
    end

endmodule

[design/fcm_index.sv]
// palette index stage: picks the two knot colors and the blend segment
module fcm_index #(
    parameter int MAX_COLORS = fcm_pkg::MAX_COLORS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  fcm_pkg::cfg_t               cfg,
    input  logic [fcm_pkg::CHAN_W-1:0]  gray,
    output fcm_pkg::knot_t              knot_reg
);
    import fcm_pkg::*;

    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] n_m1;
    logic [CNT_W-1:0] band;
    logic [CNT_W-1:0] low;
    logic [10:0]      band_prod;
    logic [10:0]      low_prod;
    seg_t             seg;
    knot_t            knot_next;

    assign n = (cfg.color_count > CNT_W'(MAX_COLORS)) ? CNT_W'(MAX_COLORS)
                                                      : cfg.color_count;
    assign n_m1      = n - CNT_W'(1);
    assign band_prod = 11'(n) * 11'(gray);
    assign low_prod  = 11'(n_m1) * 11'(gray);

    always_comb begin
        band = div255(band_prod);
        if (band > n_m1) begin
            band = n_m1;
        end
        low = div255(low_prod);
        if (low > n - CNT_W'(2)) begin
            low = n - CNT_W'(2);
        end
        seg = seg_lookup(n, low);

        knot_next = '{off: '0, span: 8'd1, recip: '0, c_lo: '0, c_hi: '0};
        if (n == '0) begin
            // empty palette stays black
            knot_next.c_lo = '0;
            knot_next.c_hi = '0;
        end else if (!cfg.soft_mode) begin
            knot_next.c_lo = cfg.colors[band];
            knot_next.c_hi = cfg.colors[band];
        end else if (n == CNT_W'(1)) begin
            knot_next.c_lo = cfg.colors[0];
            knot_next.c_hi = cfg.colors[0];
        end else begin
            knot_next.off   = gray - seg.l;
            knot_next.span  = seg.span;
            knot_next.recip = seg.recip;
            knot_next.c_lo  = cfg.colors[low];
            knot_next.c_hi  = cfg.colors[low + CNT_W'(1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            knot_reg <= knot_next;
        end
    end

endmodule

[design/fcm_lane.sv]
// one color channel: scaled difference, reciprocal divide, floor and clamp
module fcm_lane (
    input  logic                         aclk,
    input  fcm_pkg::pipe_ctl_t           ctl,
    input  logic [fcm_pkg::CHAN_W-1:0]   off,
    input  logic [fcm_pkg::CHAN_W-1:0]   span,
    input  logic [fcm_pkg::RECIP_W-1:0]  recip,
    input  logic [fcm_pkg::CHAN_W-1:0]   c_lo,
    input  logic [fcm_pkg::CHAN_W-1:0]   c_hi,
    output logic [fcm_pkg::CHAN_W-1:0]   chan_reg
);
    import fcm_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;
    localparam int REM_W  = CHAN_W + 1;
    localparam int FULL_W = PROD_W + RECIP_W;

    // stage 2: magnitude of offset times color step
    logic [PROD_W-1:0]  mag2_reg;
    logic               neg2_reg;
    logic [CHAN_W-1:0]  cl2_reg, span2_reg;
    logic [RECIP_W-1:0] recip2_reg;
    logic [CHAN_W-1:0]  step_abs;
    logic               step_neg;

    // stage 3: quotient estimate
    logic [PROD_W-1:0]  mag3_reg;
    logic               neg3_reg;
    logic [CHAN_W-1:0]  cl3_reg, span3_reg, q3_reg;
    logic [FULL_W-1:0]  est_full;

    // stage 4: remainder of the estimate
    logic [REM_W-1:0]   rem4_reg;
    logic               neg4_reg;
    logic [CHAN_W-1:0]  cl4_reg, span4_reg, q4_reg;
    logic [PROD_W-1:0]  qs;
    logic [PROD_W-1:0]  rem_full;

    // stage 5: correction, floor toward minus infinity, clamp
    logic [REM_W-1:0]   q_adj, rem_adj, up;
    logic [REM_W:0]     sum;
    logic [CHAN_W-1:0]  chan_next;

    assign step_neg = c_hi < c_lo;
    assign step_abs = step_neg ? (c_lo - c_hi) : (c_hi - c_lo);
    assign est_full = FULL_W'(mag2_reg) * FULL_W'(recip2_reg);
    assign qs       = PROD_W'(q3_reg) * PROD_W'(span3_reg);
    assign rem_full = mag3_reg - qs;

    always_comb begin
        if (rem4_reg >= REM_W'(span4_reg)) begin
            q_adj   = REM_W'(q4_reg) + REM_W'(1);
            rem_adj = rem4_reg - REM_W'(span4_reg);
        end else begin
            q_adj   = REM_W'(q4_reg);
            rem_adj = rem4_reg;
        end
        up = (neg4_reg && rem_adj != '0) ? q_adj + REM_W'(1) : q_adj;
        if (neg4_reg) begin
            sum       = (REM_W + 1)'(cl4_reg) - (REM_W + 1)'(up);
            chan_next = (up > REM_W'(cl4_reg)) ? '0 : sum[CHAN_W-1:0];
        end else begin
            sum       = (REM_W + 1)'(cl4_reg) + (REM_W + 1)'(up);
            chan_next = (sum > (REM_W + 1)'(255)) ? 8'hFF : sum[CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            mag2_reg   <= PROD_W'(off) * PROD_W'(step_abs);
            neg2_reg   <= step_neg;
            cl2_reg    <= c_lo;
            span2_reg  <= span;
            recip2_reg <= recip;
        end
        if (ctl.en[3]) begin
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            cl3_reg   <= cl2_reg;
            span3_reg <= span2_reg;
            q3_reg    <= est_full[RECIP_SHIFT +: CHAN_W];
        end
        if (ctl.en[4]) begin
            rem4_reg  <= rem_full[REM_W-1:0];
            neg4_reg  <= neg3_reg;
            cl4_reg   <= cl3_reg;
            span4_reg <= span3_reg;
            q4_reg    <= q3_reg;
        end
        if (ctl.en[5]) begin
            chan_reg <= chan_next;
        end
    end

endmodule

[design/gray_to_false_color_map_top.sv]
// top level of the false-color mapper: apb registers, index stage, three color lanes
//
// Each transaction on the input stream is one gray-plus-alpha pixel; each
// transaction on the output stream is the alpha byte and the mapped RGB color.
// The pipeline takes one pixel per clock and keeps that rate as long as the
// output side is ready; a pixel passes six register stages (input register,
// palette index stage, then four stages per color lane: product, reciprocal
// multiply, remainder, and floor/clamp) on its way to the output. Every stage
// holds when the stage after it is full and stalled, so backpressure ripples
// back to s_tready with no loss. Blend division uses a per-segment reciprocal
// from a constant table plus one correction step, so no divider sits in the
// path. The user must write configuration through the apb port only while no
// pixel is in flight; the block does not enforce this. color_count above
// MAX_COLORS is saturated.
module gray_to_false_color_map_top #(
    parameter int MAX_COLORS = fcm_pkg::MAX_COLORS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcm_pkg::ADDR_W-1:0]  paddr,
    input  logic [fcm_pkg::DATA_W-1:0]  pwdata,
    output logic [fcm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // pixel input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,  // gray [7:0], alpha [15:8]
    // color output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata   // out_alpha, red, green, blue from bit 0
);
    import fcm_pkg::*;

    cfg_t                  cfg;
    knot_t                 knot;
    pipe_ctl_t             ctl;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [CHAN_W-1:0]     gray_reg;
    logic [CHAN_W-1:0]     alpha_reg [NUM_STAGES];
    logic [CHAN_W-1:0]     red, green, blue;

    fcm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage loads when it is empty or its content moves on this cycle
    always_comb begin
        ctl.en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !valid_reg[k] || ctl.en[k+1];
        end
    end

    assign s_tready = ctl.en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ctl.en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl.en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // input register and alpha delay line
    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            gray_reg     <= s_tdata[CHAN_W-1:0];
            alpha_reg[0] <= s_tdata[2*CHAN_W-1:CHAN_W];
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctl.en[k]) begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
    end

    fcm_index #(
        .MAX_COLORS (MAX_COLORS)
    ) u_index (
        .aclk     (aclk),
        .en       (ctl.en[1]),
        .cfg      (cfg),
        .gray     (gray_reg),
        .knot_reg (knot)
    );

    fcm_lane u_lane_red (
        .aclk     (aclk),
        .ctl      (ctl),
        .off      (knot.off),
        .span     (knot.span),
        .recip    (knot.recip),
        .c_lo     (knot.c_lo[23:16]),
        .c_hi     (knot.c_hi[23:16]),
        .chan_reg (red)
    );

    fcm_lane u_lane_green (
        .aclk     (aclk),
        .ctl      (ctl),
        .off      (knot.off),
        .span     (knot.span),
        .recip    (knot.recip),
        .c_lo     (knot.c_lo[15:8]),
        .c_hi     (knot.c_hi[15:8]),
        .chan_reg (green)
    );

    fcm_lane u_lane_blue (
        .aclk     (aclk),
        .ctl      (ctl),
        .off      (knot.off),
        .span     (knot.span),
        .recip    (knot.recip),
        .c_lo     (knot.c_lo[7:0]),
        .c_hi     (knot.c_hi[7:0]),
        .chan_reg (blue)
    );

    assign m_tdata = {blue, green, red, alpha_reg[NUM_STAGES-1]};

endmodule

[design/fcm_checker.sv]
// port-level checks of the false-color mapper and their binding
module fcm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transaction changed");

    // pipeline is empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("pipeline not empty after reset");

    // a ready sink never stalls the source
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // with the sink ready while it is in flight, an accepted pixel reaches the output with its alpha
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_tvalid && s_tready, 6) && $past(aresetn, 6) &&
        $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) &&
        $past(m_tready, 4) && $past(m_tready, 5) &&
        $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3) &&
        $past(aresetn, 4) && $past(aresetn, 5)
        |-> m_tvalid && m_tdata[7:0] == $past(s_tdata[15:8], 6))
        else $error("pixel lost or alpha corrupted in flight");

endmodule

bind gray_to_false_color_map_top fcm_checker u_fcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
